// ----- src/pct_pkg.sv -----
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants for the power confirmation tracker: event and
// phase codes, the request and response beats, controller/datapath links.
// ----------------------------------------------------------------------------
package pct_pkg;

   // Default table depth
   localparam int MAX_DEVICES_DEF = 8;

   // Configuration space: one register, byte addressed
   localparam int           CSR_ADDR_W      = 3;
   localparam logic         CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [15:0]  TIMEOUT_RESET   = 16'd10000;

   typedef enum logic [1:0] {
      FUNC_EXPECT  = 2'd0,
      FUNC_OBSERVE = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_BUSY    = 2'd1,
      PHASE_DONE    = 2'd2,
      PHASE_TIMEOUT = 2'd3
   } phase_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] device_tag;
      logic        want_on;
      logic        already_there;
      logic        reported_on;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      phase_type   phase_out;
      logic        newly_confirmed;
      logic [3:0]  entry_total;
      logic [3:0]  confirmed_total;
      logic [3:0]  failed_total;
      logic        session_target_on;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_APPLY = 2'd2,
      ST_RESP  = 2'd3
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic apply;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

// ----- src/power_confirm_tracker.sv -----
// ----------------------------------------------------------------------------
// power_confirm_tracker
// The response beat is strobed after the table search and the apply state that
//   follow start; the search steps over at most MAX_DEVICES table entries.
// The one-entry-per-cycle tag search runs before any new event is taken, and a
//   new event is taken only when idle. The receiver cannot stall the response.
// Reset (synchronous, active high): session idle, table empty, timeout 10000.
// ----------------------------------------------------------------------------
module power_confirm_tracker #(
   parameter int MAX_DEVICES = pct_pkg::MAX_DEVICES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  pct_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output pct_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pct_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   pct_pkg::ctrl_cmd_type  cmd;
   pct_pkg::dp_status_type status;
   logic [15:0]            timeout_limit;

   pct_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .timeout_limit (timeout_limit)
   );

   pct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   pct_dpath #(
      .MAX_DEVICES (MAX_DEVICES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .timeout_limit (timeout_limit),
      .rsp_data      (rsp_data)
   );

endmodule

// ----- src/pct_csr.sv -----
// ----------------------------------------------------------------------------
// pct_csr
// APB register block holding the session timeout in milliseconds.
// ----------------------------------------------------------------------------
module pct_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output logic [15:0]                      timeout_limit
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        hit_timeout;

   assign pready      = 1'b1;
   assign hit_timeout = (paddr[pct_pkg::CSR_ADDR_W-1:2] == pct_pkg::CSR_IDX_TIMEOUT);

   // Take the write beat in the access phase
   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && pready && hit_timeout) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pct_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Read back
   assign prdata        = hit_timeout ? {16'd0, timeout_ff} : 32'd0;
   assign timeout_limit = timeout_ff;

endmodule

// ----- src/pct_ctrl.sv -----
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: accept an event, walk the table, apply the update, present the
// response beat for one cycle.
// ----------------------------------------------------------------------------
module pct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  pct_pkg::dp_status_type status,
   output pct_pkg::ctrl_cmd_type  cmd
);

   pct_pkg::ctrl_state_type state_ff;
   pct_pkg::ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pct_pkg::ST_IDLE: begin
            if (start) begin
               state_in = pct_pkg::ST_SCAN;
            end
         end
         pct_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = pct_pkg::ST_APPLY;
            end
         end
         pct_pkg::ST_APPLY: begin
            state_in = pct_pkg::ST_RESP;
         end
         pct_pkg::ST_RESP: begin
            state_in = pct_pkg::ST_IDLE;
         end
         default: begin
            state_in = pct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd        = '0;
      case (state_ff)
         pct_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         pct_pkg::ST_SCAN: begin
            cmd.step = !status.scan_done;
         end
         pct_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         pct_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- src/pct_dpath.sv -----
// ----------------------------------------------------------------------------
// pct_dpath
// Session state and device table. Holds the captured event, searches the
// table one entry per cycle and applies the outcome of the event.
// ----------------------------------------------------------------------------
module pct_dpath #(
   parameter int MAX_DEVICES = pct_pkg::MAX_DEVICES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pct_pkg::ctrl_cmd_type  cmd,
   output pct_pkg::dp_status_type status,
   input  pct_pkg::req_type       req_data,
   input  logic [15:0]            timeout_limit,
   output pct_pkg::rsp_type       rsp_data
);

   localparam int CW = $clog2(MAX_DEVICES + 1);
   localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

   // Captured event
   pct_pkg::func_type func_ff, func_in;
   logic [31:0]       tag_ff, tag_in;
   logic              want_ff, want_in;
   logic              there_ff, there_in;
   logic              rep_ff, rep_in;
   logic [31:0]       now_ff, now_in;

   // Search state
   logic [CW-1:0]     idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;

   // Session state
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      confd_ff, confd_in;
   pct_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        opened_ff, opened_in;
   logic               fresh_ff, fresh_in;
   logic               first_ff;

   // Device table
   logic [31:0]        tags_ff    [MAX_DEVICES];
   logic               targets_ff [MAX_DEVICES];
   logic               conf_ff    [MAX_DEVICES];

   logic [CW-1:0]      count_inc;
   logic [CW-1:0]      confd_inc;
   logic [CW-1:0]      confd_add;
   logic [31:0]        elapsed;
   logic               add_ok;
   logic               confirm_ok;

   assign count_inc = count_ff + 1'b1;
   assign confd_inc = confd_ff + 1'b1;
   assign confd_add = confd_ff + CW'(there_ff);
   assign elapsed   = now_ff - opened_ff;

   assign add_ok = (func_ff == pct_pkg::FUNC_EXPECT) && !hit_ff &&
                   (count_ff < CW'(MAX_DEVICES));
   assign confirm_ok = (func_ff == pct_pkg::FUNC_OBSERVE) &&
                       (phase_ff != pct_pkg::PHASE_IDLE) && hit_ff &&
                       !conf_ff[hit_idx_ff] && (rep_ff == targets_ff[hit_idx_ff]);

   // Search ends on a match or past the last entry
   assign status.scan_done = hit_ff || (idx_ff >= count_ff);

   always_comb begin
      func_in    = func_ff;
      tag_in     = tag_ff;
      want_in    = want_ff;
      there_in   = there_ff;
      rep_in     = rep_ff;
      now_in     = now_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      count_in   = count_ff;
      confd_in   = confd_ff;
      phase_in   = phase_ff;
      opened_in  = opened_ff;
      fresh_in   = fresh_ff;

      // Capture the event; an expect with no session running opens a fresh one
      if (cmd.load) begin
         func_in    = req_data.func;
         tag_in     = req_data.device_tag;
         want_in    = req_data.want_on;
         there_in   = req_data.already_there;
         rep_in     = req_data.reported_on;
         now_in     = req_data.now_ms;
         idx_in     = '0;
         hit_in     = 1'b0;
         hit_idx_in = '0;
         fresh_in   = 1'b0;
         if ((req_data.func == pct_pkg::FUNC_EXPECT) &&
             (phase_ff != pct_pkg::PHASE_BUSY)) begin
            count_in  = '0;
            confd_in  = '0;
            phase_in  = pct_pkg::PHASE_BUSY;
            opened_in = req_data.now_ms;
         end
      end

      // Compare one entry per cycle
      if (cmd.step) begin
         if (tags_ff[idx_ff[IW-1:0]] == tag_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = idx_ff[IW-1:0];
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      // Apply the event
      if (cmd.apply) begin
         case (func_ff)
            pct_pkg::FUNC_EXPECT: begin
               if (add_ok) begin
                  count_in = count_inc;
                  confd_in = confd_add;
                  if (confd_add == count_inc) begin
                     phase_in = pct_pkg::PHASE_DONE;
                  end
               end
            end
            pct_pkg::FUNC_OBSERVE: begin
               if (confirm_ok) begin
                  confd_in = confd_inc;
                  fresh_in = 1'b1;
                  if (confd_inc == count_ff) begin
                     phase_in = pct_pkg::PHASE_DONE;
                  end
               end
            end
            pct_pkg::FUNC_TICK: begin
               if ((phase_ff == pct_pkg::PHASE_BUSY) &&
                   (elapsed >= {16'd0, timeout_limit})) begin
                  phase_in = pct_pkg::PHASE_TIMEOUT;
               end
            end
            pct_pkg::FUNC_CLEAR: begin
               count_in  = '0;
               confd_in  = '0;
               phase_in  = pct_pkg::PHASE_IDLE;
               opened_in = '0;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         hit_ff    <= 1'b0;
         count_ff  <= '0;
         confd_ff  <= '0;
         phase_ff  <= pct_pkg::PHASE_IDLE;
         opened_ff <= '0;
         fresh_ff  <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         hit_ff    <= hit_in;
         count_ff  <= count_in;
         confd_ff  <= confd_in;
         phase_ff  <= phase_in;
         opened_ff <= opened_in;
         fresh_ff  <= fresh_in;
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      tag_ff     <= tag_in;
      want_ff    <= want_in;
      there_ff   <= there_in;
      rep_ff     <= rep_in;
      now_ff     <= now_in;
      hit_idx_ff <= hit_idx_in;
   end

   // Table writes: add at the end, or mark a matched entry confirmed
   always_ff @(posedge clock) begin
      if (cmd.apply && add_ok) begin
         tags_ff[count_ff[IW-1:0]]    <= tag_ff;
         targets_ff[count_ff[IW-1:0]] <= want_ff;
         conf_ff[count_ff[IW-1:0]]    <= there_ff;
         if (count_ff == '0) begin
            first_ff <= want_ff;
         end
      end else if (cmd.apply && confirm_ok) begin
         conf_ff[hit_idx_ff] <= 1'b1;
      end
   end

   // Response fields; entries not confirmed in a timed-out session have failed
   always_comb begin
      rsp_data.phase_out         = phase_ff;
      rsp_data.newly_confirmed   = fresh_ff;
      rsp_data.entry_total       = 4'(count_ff);
      rsp_data.confirmed_total   = 4'(confd_ff);
      rsp_data.failed_total      = (phase_ff == pct_pkg::PHASE_TIMEOUT) ?
                                   4'(count_ff - confd_ff) : 4'd0;
      rsp_data.session_target_on = (count_ff != '0) && first_ff;
   end

endmodule

// ----- src/pct_checker.sv -----
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks on the tracker's handshake and response fields.
// ----------------------------------------------------------------------------
module pct_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input pct_pkg::rsp_type rsp_data
);

   // A taken event holds off the next one
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted event");

   // The response beat falls inside the busy window and lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy ##1 !rsp_strobe))
      else $error("response beat outside busy or longer than one cycle");

   // An idle session carries no entries
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.phase_out == pct_pkg::PHASE_IDLE)) |->
      ((rsp_data.entry_total == 4'd0) && (rsp_data.confirmed_total == 4'd0)))
      else $error("idle session reports entries");

   // Failures only exist after a timeout
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.phase_out != pct_pkg::PHASE_TIMEOUT)) |->
      (rsp_data.failed_total == 4'd0))
      else $error("failed devices reported without a timeout");

endmodule

bind power_confirm_tracker pct_checker u_pct_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the power confirmation tracker. A short table of
// events walks every event kind, duplicate and full tables, the timeout edge
// and wrap of the clock. Random device sessions then run under several
// timeout settings, each written through the register port and read back.
// Each status beat is checked against the table's value or a behavioural tracker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DEV        = pct_pkg::MAX_DEVICES_DEF;
   localparam int CSR_AW         = pct_pkg::CSR_ADDR_W;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 150;
   localparam logic [CSR_AW-1:0] TIMEOUT_ADDR = CSR_AW'(4 * pct_pkg::CSR_IDX_TIMEOUT);

   typedef enum logic [1:0] {
      OUT_PENDING   = 2'd0,
      OUT_CONFIRMED = 2'd1,
      OUT_FAILED    = 2'd2
   } outcome_type;

   typedef struct {
      pct_pkg::req_type ev;
      bit               typed;
      pct_pkg::rsp_type want;
   } stim_row_type;

   // DUT connections
   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              busy;
   pct_pkg::req_type  req_data = '0;
   logic              rsp_strobe;
   pct_pkg::rsp_type  rsp_data;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [CSR_AW-1:0] paddr    = '0;
   logic [31:0]       pwdata   = '0;
   logic [31:0]       prdata;
   logic              pready;

   // Tracker state mirrored by the bench
   logic [31:0]        dev_tag     [MAX_DEV];
   logic               dev_target  [MAX_DEV];
   outcome_type        dev_outcome [MAX_DEV];
   int unsigned        dev_count;
   pct_pkg::phase_type sess_phase;
   logic [31:0]        sess_opened;
   logic [15:0]        timeout_val;

   pct_pkg::rsp_type expected_status [$];
   stim_row_type     script [$];
   int unsigned      status_errors  = 0;
   int unsigned      accepted_items = 0;
   int unsigned      quiet_cycles   = 0;

   power_confirm_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioural tracker
   // ------------------------------------------------------------------------
   function automatic int count_outcome(outcome_type oc);
      int n;
      n = 0;
      for (int i = 0; i < dev_count; i++)
         if (dev_outcome[i] == oc) n++;
      return n;
   endfunction

   function automatic int lookup_tag(logic [31:0] tag);
      for (int i = 0; i < dev_count; i++)
         if (dev_tag[i] == tag) return i;
      return -1;
   endfunction

   function automatic void drop_session();
      dev_count   = 0;
      sess_phase  = pct_pkg::PHASE_IDLE;
      sess_opened = '0;
   endfunction

   function automatic void mark_resolved();
      if (count_outcome(OUT_CONFIRMED) == dev_count) sess_phase = pct_pkg::PHASE_DONE;
   endfunction

   // Apply one event to the mirrored state and return the status it reports
   function automatic pct_pkg::rsp_type track_event(pct_pkg::req_type ev);
      pct_pkg::rsp_type r;
      int               idx;
      logic             fresh;
      logic [31:0]      elapsed;
      fresh = 1'b0;
      case (ev.func)
         pct_pkg::FUNC_EXPECT: begin
            // open a fresh session unless one is running
            if (sess_phase != pct_pkg::PHASE_BUSY) begin
               drop_session();
               sess_phase  = pct_pkg::PHASE_BUSY;
               sess_opened = ev.now_ms;
            end
            if (lookup_tag(ev.device_tag) < 0 && dev_count < MAX_DEV) begin
               dev_tag[dev_count]     = ev.device_tag;
               dev_target[dev_count]  = ev.want_on;
               dev_outcome[dev_count] = ev.already_there ? OUT_CONFIRMED : OUT_PENDING;
               dev_count++;
               mark_resolved();
            end
         end
         pct_pkg::FUNC_OBSERVE: begin
            if (sess_phase != pct_pkg::PHASE_IDLE) begin
               idx = lookup_tag(ev.device_tag);
               if (idx >= 0 && dev_outcome[idx] != OUT_CONFIRMED &&
                   ev.reported_on == dev_target[idx]) begin
                  dev_outcome[idx] = OUT_CONFIRMED;
                  mark_resolved();
                  fresh = 1'b1;
               end
            end
         end
         pct_pkg::FUNC_TICK: begin
            // elapsed time wraps with the millisecond counter
            elapsed = ev.now_ms - sess_opened;
            if (sess_phase == pct_pkg::PHASE_BUSY && elapsed >= {16'h0, timeout_val}) begin
               for (int i = 0; i < dev_count; i++)
                  if (dev_outcome[i] == OUT_PENDING) dev_outcome[i] = OUT_FAILED;
               sess_phase = pct_pkg::PHASE_TIMEOUT;
            end
         end
         default: begin
            drop_session();
         end
      endcase
      r.phase_out         = sess_phase;
      r.newly_confirmed   = fresh;
      r.entry_total       = 4'(dev_count);
      r.confirmed_total   = 4'(count_outcome(OUT_CONFIRMED));
      r.failed_total      = 4'(count_outcome(OUT_FAILED));
      r.session_target_on = (dev_count > 0) ? dev_target[0] : 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------
   function automatic pct_pkg::req_type mk_ev(pct_pkg::func_type f, logic [31:0] tag,
                                              bit want, bit there, bit rep,
                                              logic [31:0] now);
      pct_pkg::req_type ev;
      ev.func          = f;
      ev.device_tag    = tag;
      ev.want_on       = want;
      ev.already_there = there;
      ev.reported_on   = rep;
      ev.now_ms        = now;
      return ev;
   endfunction

   function automatic pct_pkg::rsp_type mk_rsp(pct_pkg::phase_type p, bit fresh, int ent,
                                               int conf, int fail, bit tgt);
      pct_pkg::rsp_type r;
      r.phase_out         = p;
      r.newly_confirmed   = fresh;
      r.entry_total       = 4'(ent);
      r.confirmed_total   = 4'(conf);
      r.failed_total      = 4'(fail);
      r.session_target_on = tgt;
      return r;
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic pct_pkg::req_type random_event();
      return mk_ev(pct_pkg::func_type'($urandom_range(0, 3)), $urandom(), coin(),
                   coin(), coin(), $urandom());
   endfunction

   // Small pool of tags so that duplicates turn up, with the odd wild one
   function automatic logic [31:0] pick_tag();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         default: return 32'($urandom_range(1, 14));
      endcase
   endfunction

   function automatic string fmt_rsp(pct_pkg::rsp_type r);
      return $sformatf("ph=%0d new=%0b ent=%0d conf=%0d fail=%0d tgt=%0b",
                       r.phase_out, r.newly_confirmed, r.entry_total,
                       r.confirmed_total, r.failed_total, r.session_target_on);
   endfunction

   task automatic add_row(pct_pkg::req_type ev, bit typed, pct_pkg::rsp_type want);
      stim_row_type row;
      row.ev    = ev;
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endtask

   task automatic report_status(string what, pct_pkg::rsp_type want,
                                pct_pkg::rsp_type got);
      status_errors++;
      if (status_errors <= 10)
         $display("%0t %s: expected %s, got %s", $time, what, fmt_rsp(want),
                  fmt_rsp(got));
   endtask

   // ------------------------------------------------------------------------
   // Event channel: hold the beat until taken, then log its expected status
   // ------------------------------------------------------------------------
   task automatic send_event(pct_pkg::req_type ev, bit typed = 1'b0,
                             pct_pkg::rsp_type want = '0);
      pct_pkg::rsp_type predicted;
      start    <= 1'b1;
      req_data <= ev;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predicted = track_event(ev);
      expected_status.push_back(typed ? want : predicted);
      accepted_items++;
   endtask

   // Unless steady, sometimes drop start for a random gap, mostly short, sometimes long
   task automatic pace(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (!steady && r >= 50) begin
         start <= 1'b0;
         if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clock);
         else        repeat ($urandom_range(10, 40)) @(posedge clock);
      end
   endtask

   // Hold off until every status beat is back and the block is free
   task automatic drain();
      start <= 1'b0;
      while (expected_status.size() != 0 || busy) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TIMEOUT_ADDR;
      pwdata  <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      timeout_val = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= TIMEOUT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'h0, timeout_val}) begin
         status_errors++;
         if (status_errors <= 10)
            $display("%0t timeout readback: expected %0d, got %0d", $time,
                     timeout_val, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // One random session: well-formed adds, then mixed follow-up events
   // ------------------------------------------------------------------------
   task automatic run_session();
      logic [31:0]      t0;
      logic [31:0]      elapsed;
      pct_pkg::req_type ev;
      bit               steady;
      int               n_dev;
      int               n_more;
      int               r;
      int               idx;
      t0     = $urandom();
      steady = ($urandom_range(0, 3) == 0);
      n_dev  = $urandom_range(1, MAX_DEV + 1);
      n_more = $urandom_range(1, 12);
      for (int i = 0; i < n_dev; i++) begin
         ev = mk_ev(pct_pkg::FUNC_EXPECT, pick_tag(), coin(),
                    $urandom_range(0, 3) == 0, coin(), t0 + i);
         send_event(ev);
         pace(steady);
      end
      for (int i = 0; i < n_more; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            // observe a listed device, mostly with the matching state
            if (dev_count > 0 && $urandom_range(0, 7) != 0) begin
               idx = $urandom_range(0, dev_count - 1);
               ev  = mk_ev(pct_pkg::FUNC_OBSERVE, dev_tag[idx], coin(), coin(),
                           dev_target[idx] ^ ($urandom_range(0, 4) == 0), $urandom());
            end else begin
               ev = mk_ev(pct_pkg::FUNC_OBSERVE, pick_tag(), coin(), coin(), coin(),
                          $urandom());
            end
         end else if (r < 80) begin
            // tick around the timeout boundary
            case ($urandom_range(0, 3))
               0:       elapsed = {16'h0, timeout_val} - 1;
               1:       elapsed = {16'h0, timeout_val};
               2:       elapsed = $urandom_range(0, timeout_val);
               default: elapsed = $urandom();
            endcase
            ev = mk_ev(pct_pkg::FUNC_TICK, $urandom(), coin(), coin(), coin(),
                       sess_opened + elapsed);
         end else if (r < 85) begin
            ev = mk_ev(pct_pkg::FUNC_CLEAR, $urandom(), coin(), coin(), coin(),
                       $urandom());
         end else if (r < 92) begin
            ev = mk_ev(pct_pkg::FUNC_EXPECT, pick_tag(), coin(), coin(), coin(),
                       t0 + 100 + i);
         end else begin
            ev = random_event();
         end
         send_event(ev);
         pace(steady);
      end
   endtask

   // ------------------------------------------------------------------------
   // Status monitor: the receiver cannot stall, so check every strobe
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_status.size() == 0) begin
            report_status("unexpected status beat", '0, rsp_data);
         end else begin
            if (rsp_data.phase_out         !== expected_status[0].phase_out ||
                rsp_data.newly_confirmed   !== expected_status[0].newly_confirmed ||
                rsp_data.entry_total       !== expected_status[0].entry_total ||
                rsp_data.confirmed_total   !== expected_status[0].confirmed_total ||
                rsp_data.failed_total      !== expected_status[0].failed_total ||
                rsp_data.session_target_on !== expected_status[0].session_target_on)
               report_status("status mismatch", expected_status[0], rsp_data);
            void'(expected_status.pop_front());
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [15:0] timeout_plan [5];
      int unsigned item_goal;

      drop_session();
      timeout_val  = pct_pkg::TIMEOUT_RESET;
      timeout_plan = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 65534)),
                       pct_pkg::TIMEOUT_RESET};

      // directed table, run at the reset timeout
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'h0, 1, 1, 1, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_IDLE, 0, 0, 0, 0, 0));
      add_row(mk_ev(pct_pkg::FUNC_TICK, 32'h0, 0, 0, 0, 32'hFFFF_FFFF), 1,
              mk_rsp(pct_pkg::PHASE_IDLE, 0, 0, 0, 0, 0));
      add_row(mk_ev(pct_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFFF), 1,
              mk_rsp(pct_pkg::PHASE_IDLE, 0, 0, 0, 0, 0));
      add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'h0, 1, 0, 0, 32'hFFFF_FFF0), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 1, 0, 0, 1));
      // duplicate tag is ignored
      add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'h0, 0, 1, 0, 32'h5), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 1, 0, 0, 1));
      add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'hFFFF_FFFF, 0, 1, 1, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 2, 1, 0, 1));
      // state mismatch, already confirmed, unknown tag
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'h0, 0, 0, 0, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 2, 1, 0, 1));
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'hFFFF_FFFF, 0, 0, 0, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 2, 1, 0, 1));
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'h1234_5678, 1, 0, 1, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 2, 1, 0, 1));
      // one short of the timeout across the clock wrap, then exactly on it
      add_row(mk_ev(pct_pkg::FUNC_TICK, 32'h0, 0, 0, 0, 32'h0000_26FF), 0, '0);
      add_row(mk_ev(pct_pkg::FUNC_TICK, 32'h0, 0, 0, 0, 32'h0000_2700), 1,
              mk_rsp(pct_pkg::PHASE_TIMEOUT, 0, 2, 1, 1, 1));
      // a failed device still confirms after the timeout
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'h0, 0, 0, 1, 32'h0), 0, '0);
      // expect in a resolved session opens a new one
      add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'hA5A5_A5A5, 0, 0, 0, 32'd100), 1,
              mk_rsp(pct_pkg::PHASE_BUSY, 0, 1, 0, 0, 0));
      for (int i = 1; i <= MAX_DEV; i++)
         add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'(i), 1'(i % 2), i == 3, 0,
                       32'(100 + i)), 0, '0);
      add_row(mk_ev(pct_pkg::FUNC_OBSERVE, 32'hA5A5_A5A5, 1, 1, 0, 32'h0), 0, '0);
      add_row(mk_ev(pct_pkg::FUNC_CLEAR, 32'h0, 0, 0, 0, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_IDLE, 0, 0, 0, 0, 0));
      // a device already confirmed resolves the session at once
      add_row(mk_ev(pct_pkg::FUNC_EXPECT, 32'h5A5A_5A5A, 1, 1, 0, 32'h0), 1,
              mk_rsp(pct_pkg::PHASE_DONE, 0, 1, 1, 0, 1));
      add_row(mk_ev(pct_pkg::FUNC_TICK, 32'h0, 0, 0, 0, 32'hFFFF_FFFF), 0, '0);

      // hold reset, then check the register's reset value
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check();

      foreach (script[i]) begin
         send_event(script[i].ev, script[i].typed, script[i].want);
         pace(1'b0);
      end

      // random sessions under each timeout, register changed only when idle
      item_goal = accepted_items;
      foreach (timeout_plan[p]) begin
         drain();
         csr_write(timeout_plan[p]);
         csr_read_check();
         item_goal += PHASE_ITEMS;
         while (accepted_items < item_goal) run_session();
      end

      // let the last beats come back
      drain();
      repeat (MAX_DEV + 4) @(posedge clock);
      if (status_errors == 0 && expected_status.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
